// ===== src/pnm_pkg.sv =====
// Shared types and constants for the tour neighbourhood-move engine.
// Depends on nothing; every other file but pnm_ram takes names from here by scope.
package pnm_pkg;

	localparam int MAX_TOWNS_DEF = 64;
	localparam int IDX_W         = 6;
	localparam int TOWN_W        = 6;
	localparam int COUNT_W       = 7;
	localparam int ACT_W         = 3;
	localparam int STAT_W        = 2;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;

	localparam logic [COUNT_W-1:0]   TOWN_COUNT_RST = COUNT_W'(64);
	// word index of the town_count register
	localparam logic [PADDR_W-3:0]   REG_TOWN_COUNT = '0;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD    = 3'd0,
		ACT_READ    = 3'd1,
		ACT_SWAP    = 3'd2,
		ACT_REVERSE = 3'd3,
		ACT_INSERT  = 3'd4
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EQUAL = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAIR_HI,
		S_PAIR_WLO,
		S_PAIR_WHI,
		S_MV_CAP,
		S_MV_WR,
		S_MV_LAST,
		S_FIN
	} seq_state_t;

endpackage

// ===== src/pnm_if.sv =====
// Valid/ready channel interfaces for command and response beats.
// Depends on pnm_pkg for field widths.
interface pnm_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [pnm_pkg::ACT_W-1:0]   action;
	logic [pnm_pkg::IDX_W-1:0]   first_index;
	logic [pnm_pkg::IDX_W-1:0]   second_index;
	logic [pnm_pkg::TOWN_W-1:0]  load_value;

	modport source (output valid, action, first_index, second_index, load_value, input ready);
	modport sink (input valid, action, first_index, second_index, load_value, output ready);
endinterface

interface pnm_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [pnm_pkg::STAT_W-1:0]  status;
	logic [pnm_pkg::TOWN_W-1:0]  read_value;

	modport source (output valid, status, read_value, input ready);
	modport sink (input valid, status, read_value, output ready);
endinterface

// ===== src/pnm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module pnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/pnm_cfg.sv =====
// APB-style configuration register block holding town_count.
// Depends on pnm_pkg.
module pnm_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pnm_pkg::PADDR_W-1:0]       paddr,
	input  logic [pnm_pkg::PDATA_W-1:0]       pwdata,
	output logic [pnm_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,
	output logic [pnm_pkg::COUNT_W-1:0]       town_count
);

	logic                              hit;
	logic [pnm_pkg::COUNT_W-1:0]       town_count_q;

	assign hit = (paddr[pnm_pkg::PADDR_W-1:2] == pnm_pkg::REG_TOWN_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			town_count_q <= pnm_pkg::TOWN_COUNT_RST;
		end else if (psel && penable && pwrite && hit) begin
			town_count_q <= pwdata[pnm_pkg::COUNT_W-1:0];
		end
	end

	assign prdata     = hit ? pnm_pkg::PDATA_W'(town_count_q) : '0;
	assign pready     = 1'b1;
	assign town_count = town_count_q;

endmodule

// ===== src/pnm_seq.sv =====
// Move sequencer: checks each command, then walks the tour RAM with
// read-modify-write steps and posts one response beat. Depends on pnm_pkg, pnm_if.
module pnm_seq #(
	parameter int MAX_TOWNS = pnm_pkg::MAX_TOWNS_DEF,
	parameter int AW        = $clog2(MAX_TOWNS)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	pnm_cmd_if.sink                        cmd,
	pnm_rsp_if.source                      rsp,
	input  logic [pnm_pkg::COUNT_W-1:0]    town_count,
	output logic                           ram_we,
	output logic [AW-1:0]                  ram_waddr,
	output logic [pnm_pkg::TOWN_W-1:0]     ram_wdata,
	output logic                           ram_re,
	output logic [AW-1:0]                  ram_raddr,
	input  logic [pnm_pkg::TOWN_W-1:0]     ram_rdata
);

	localparam int IW = pnm_pkg::IDX_W;

	pnm_pkg::seq_state_t           state_q, state_d;
	logic [pnm_pkg::ACT_W-1:0]     act_q;
	pnm_pkg::status_t              stat_q, st_new;
	logic [IW-1:0]                 lo_q, hi_q;
	logic                          up_q;
	logic [pnm_pkg::TOWN_W-1:0]    hold_q;
	logic                          rsp_valid_q;
	logic [pnm_pkg::STAT_W-1:0]    rsp_status_q;
	logic [pnm_pkg::TOWN_W-1:0]    rsp_value_q;

	logic                          a_ok, b_ok, a_lt_b, is_lr, is_move;
	logic [IW-1:0]                 lo_new, hi_new, mv_next, mv_next2;
	logic                          pair_more, fin_take;

	// position checks: a < min(town_count, MAX_TOWNS)
	assign a_ok   = ({1'b0, cmd.first_index} < town_count) &&
	                (int'(cmd.first_index) < MAX_TOWNS);
	assign b_ok   = ({1'b0, cmd.second_index} < town_count) &&
	                (int'(cmd.second_index) < MAX_TOWNS);
	assign a_lt_b = cmd.first_index < cmd.second_index;
	assign lo_new = a_lt_b ? cmd.first_index : cmd.second_index;
	assign hi_new = a_lt_b ? cmd.second_index : cmd.first_index;

	assign is_lr   = (cmd.action == pnm_pkg::ACT_LOAD) || (cmd.action == pnm_pkg::ACT_READ);
	assign is_move = (cmd.action == pnm_pkg::ACT_SWAP) ||
	                 (cmd.action == pnm_pkg::ACT_REVERSE) ||
	                 (cmd.action == pnm_pkg::ACT_INSERT);

	always_comb begin
		st_new = pnm_pkg::ST_DONE;
		if (is_lr) begin
			if (!a_ok) st_new = pnm_pkg::ST_RANGE;
		end else if (is_move) begin
			if (!a_ok || !b_ok) begin
				st_new = pnm_pkg::ST_RANGE;
			end else if (cmd.first_index == cmd.second_index) begin
				st_new = pnm_pkg::ST_EQUAL;
			end
		end
	end

	assign mv_next   = up_q ? lo_q + IW'(1) : lo_q - IW'(1);
	assign mv_next2  = up_q ? lo_q + IW'(2) : lo_q - IW'(2);
	assign pair_more = (act_q == pnm_pkg::ACT_REVERSE) && ((hi_q - lo_q) > IW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Accesses never hit one entry in the same cycle: a pair writes lo then hi
	// and the next read goes to lo+1, a shift reads two places ahead of its write.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		cmd.ready = 1'b0;
		fin_take  = 1'b0;
		unique case (state_q)
			pnm_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = pnm_pkg::S_FIN;
					if (st_new == pnm_pkg::ST_DONE) begin
						unique case (cmd.action) inside
							pnm_pkg::ACT_LOAD: begin
								ram_we    = 1'b1;
								ram_waddr = AW'(cmd.first_index);
								ram_wdata = cmd.load_value;
							end
							pnm_pkg::ACT_READ: begin
								ram_re    = 1'b1;
								ram_raddr = AW'(cmd.first_index);
							end
							pnm_pkg::ACT_SWAP, pnm_pkg::ACT_REVERSE: begin
								ram_re    = 1'b1;
								ram_raddr = AW'(lo_new);
								state_d   = pnm_pkg::S_PAIR_HI;
							end
							pnm_pkg::ACT_INSERT: begin
								ram_re    = 1'b1;
								ram_raddr = AW'(cmd.first_index);
								state_d   = pnm_pkg::S_MV_CAP;
							end
							default: begin
								state_d = pnm_pkg::S_FIN;
							end
						endcase
					end
				end
			end
			pnm_pkg::S_PAIR_HI: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(hi_q);
				state_d   = pnm_pkg::S_PAIR_WLO;
			end
			pnm_pkg::S_PAIR_WLO: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(lo_q);
				ram_wdata = ram_rdata;
				state_d   = pnm_pkg::S_PAIR_WHI;
			end
			pnm_pkg::S_PAIR_WHI: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(hi_q);
				ram_wdata = hold_q;
				if (pair_more) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(lo_q + IW'(1));
					state_d   = pnm_pkg::S_PAIR_HI;
				end else begin
					state_d = pnm_pkg::S_FIN;
				end
			end
			pnm_pkg::S_MV_CAP: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(mv_next);
				state_d   = pnm_pkg::S_MV_WR;
			end
			pnm_pkg::S_MV_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(lo_q);
				ram_wdata = ram_rdata;
				if (mv_next == hi_q) begin
					state_d = pnm_pkg::S_MV_LAST;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = AW'(mv_next2);
				end
			end
			pnm_pkg::S_MV_LAST: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(hi_q);
				ram_wdata = hold_q;
				state_d   = pnm_pkg::S_FIN;
			end
			pnm_pkg::S_FIN: begin
				// post the beat once the output register is free
				if (!rsp_valid_q || rsp.ready) begin
					fin_take = 1'b1;
					state_d  = pnm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pnm_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == pnm_pkg::S_IDLE && cmd.valid) begin
			act_q  <= cmd.action;
			stat_q <= st_new;
			up_q   <= a_lt_b;
			if (cmd.action == pnm_pkg::ACT_INSERT) begin
				lo_q <= cmd.first_index;
				hi_q <= cmd.second_index;
			end else begin
				lo_q <= lo_new;
				hi_q <= hi_new;
			end
		end
		if (state_q == pnm_pkg::S_PAIR_HI || state_q == pnm_pkg::S_MV_CAP) begin
			hold_q <= ram_rdata;
		end
		if (state_q == pnm_pkg::S_PAIR_WHI) begin
			lo_q <= lo_q + IW'(1);
			hi_q <= hi_q - IW'(1);
		end
		if (state_q == pnm_pkg::S_MV_WR) begin
			lo_q <= mv_next;
		end
		if (fin_take) begin
			rsp_status_q <= stat_q;
			rsp_value_q  <= (act_q == pnm_pkg::ACT_READ && stat_q == pnm_pkg::ST_DONE) ?
			                ram_rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.read_value = rsp_value_q;

endmodule

// ===== src/permutation_neighbour_move_top.sv =====
// Top level of the tour neighbourhood-move engine: config block, sequencer, tour RAM.
// Depends on pnm_pkg, pnm_if, pnm_ram, pnm_cfg, pnm_seq.
//
//   port   dir    kind        beat contents
//   cmd    in     valid/ready action, first_index, second_index, load_value
//   rsp    out    valid/ready status, read_value
//   apb    in     APB write   town_count at byte address 0
//
// Load and read touch the RAM once; a rejected or unknown command does not touch it.
// Swap and reverse read both ends of a pair and write them back exchanged; insert
// shifts every entry between the positions by one place and puts the held one last.
// The single-read, single-write tour RAM sets the pace: one entry moves per cycle
// on insert, a pair takes two reads and two writes on reverse.
// Reset clears control state only; the tour RAM holds garbage until loaded.
// A stalled rsp beat holds in the output register; the next command can be
// accepted meanwhile, and its response waits for the register to free up.
module permutation_neighbour_move_top #(
	parameter int MAX_TOWNS = pnm_pkg::MAX_TOWNS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pnm_cmd_if.sink                       cmd,
	pnm_rsp_if.source                     rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pnm_pkg::PADDR_W-1:0]   paddr,
	input  logic [pnm_pkg::PDATA_W-1:0]   pwdata,
	output logic [pnm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int AW = $clog2(MAX_TOWNS);

	logic [pnm_pkg::COUNT_W-1:0] town_count;
	logic                        ram_we, ram_re;
	logic [AW-1:0]               ram_waddr, ram_raddr;
	logic [pnm_pkg::TOWN_W-1:0]  ram_wdata, ram_rdata;

	pnm_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.town_count (town_count)
	);

	pnm_ram #(
		.WIDTH (pnm_pkg::TOWN_W),
		.DEPTH (MAX_TOWNS)
	) u_tour_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pnm_seq #(
		.MAX_TOWNS (MAX_TOWNS),
		.AW        (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rsp        (rsp),
		.town_count (town_count),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	// one command at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command accepted while sequencer busy");

	// no read and write of the same entry in one cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("tour RAM read and write collide");

	a_write_in_depth: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> int'(ram_waddr) < MAX_TOWNS)
		else $error("tour RAM write beyond depth");

endmodule
